// File: sv/cdd_pkg.sv
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned DayW   = 7;
  localparam int unsigned MonthW = 7;
  localparam int unsigned YearW  = 14;
  localparam int unsigned NumW   = 23;

  typedef logic [DayW-1:0]          day_t;
  typedef logic [MonthW-1:0]        month_t;
  typedef logic [YearW-1:0]         year_t;
  typedef logic [NumW-1:0]          day_num_t;
  typedef logic signed [NumW-1:0]   diff_t;

  localparam logic [8:0]  DaysPerYear   = 9'd365;
  localparam logic [4:0]  DaysLongMonth = 5'd31;
  localparam month_t      MonthFeb      = 7'd2;
  localparam month_t      MonthOverflow = 7'd13;

  // x / 25 for x < 4096: ceil(2^20 / 25), exact over that range
  localparam logic [15:0] Div25Recip = 16'd41944;
  // 25 * Inv25 == 1 mod 4096; x is a multiple of 25 iff x * Inv25 mod 4096 <= 4095 / 25
  localparam logic [11:0] Inv25      = 12'd3113;
  localparam logic [11:0] Mult25Lim  = 12'd163;

  function automatic logic [7:0] div25(input logic [11:0] x);
    logic [27:0] prod;
    prod = {16'b0, x} * {12'b0, Div25Recip};
    return prod[27:20];
  endfunction

  function automatic logic is_mult25(input logic [11:0] x);
    logic [23:0] prod;
    prod = {12'b0, x} * {12'b0, Inv25};
    return prod[11:0] <= Mult25Lim;
  endfunction

  // days before month (idx + 1) in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: sv/cdd_day_number.sv
`timescale 1ns / 1ps

module cdd_day_number (
  input  cdd_pkg::day_t     day_i,
  input  cdd_pkg::month_t   month_i,
  input  cdd_pkg::year_t    year_i,
  output cdd_pkg::day_num_t day_num_o
);
  import cdd_pkg::*;

  year_t      prev_year;
  logic [7:0] div100;
  logic [7:0] div400;
  logic [11:0] leaps;
  logic        is_leap;
  logic [6:0]  extra_months;
  logic [11:0] month_days;
  day_num_t    year_days;

  // leap years in 0 .. year-1; year 0 itself is leap
  assign prev_year = year_i - 14'd1;
  assign div100    = div25(prev_year[13:2]);
  assign div400    = div25({2'b0, prev_year[13:4]});

  always_comb begin
    if (year_i == '0) begin
      leaps = '0;
    end else begin
      leaps = prev_year[13:2] + 12'd1 - {4'b0, div100} + {4'b0, div400};
    end
  end

  // y % 4 == 0 and (y / 4 not a multiple of 25, or y % 16 == 0 and y / 16 a multiple of 25)
  assign is_leap = (year_i[1:0] == 2'b00) &&
                   (!is_mult25(year_i[13:2]) ||
                    ((year_i[3:0] == 4'b0000) && is_mult25({2'b0, year_i[13:4]})));

  assign extra_months = month_i - MonthOverflow;

  always_comb begin
    if (month_i == '0) begin
      month_days = '0;
    end else if (month_i <= MonthOverflow) begin
      month_days = {3'b0, cum_days(4'(month_i - 7'd1))};
    end else begin
      // past December every month counts 31 days
      month_days = {3'b0, DaysPerYear} + {5'b0, extra_months} * {7'b0, DaysLongMonth};
    end
  end

  assign year_days = {9'b0, year_i} * {14'b0, DaysPerYear};

  assign day_num_o = year_days + {11'b0, leaps} + {11'b0, month_days} +
                     {22'b0, (month_i > MonthFeb) && is_leap} + {16'b0, day_i};

endmodule

// File: sv/calendar_day_difference_core.sv
`timescale 1ns / 1ps

// Signed day count between two proleptic Gregorian dates.
//
// Input channel (in_valid_i / in_ready_o): one request carries both dates as
// binary day, month and year fields. Output channel (out_valid_o / out_ready_i)
// returns one result per request: second day number minus first, 23-bit
// two's complement.
//
// Pipeline: input register -> two day-number units and a subtract -> result
// register. An accepted request waits in the input register, its difference
// in the result register. Throughput, one request per cycle while the receiver
// keeps up, is set by the single combinational day-number pass in between.
//
// Backpressure: each register advances when the one after it is empty or
// being drained. With the receiver stalled, the input register still takes
// one more request; in_ready_o drops only when both registers are full.
//
// Reset clears both valid flags; no request is in flight afterwards.

module calendar_day_difference_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cdd_pkg::day_t     first_day_i,
  input  cdd_pkg::month_t   first_month_i,
  input  cdd_pkg::year_t    first_year_i,
  input  cdd_pkg::day_t     second_day_i,
  input  cdd_pkg::month_t   second_month_i,
  input  cdd_pkg::year_t    second_year_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cdd_pkg::diff_t    day_difference_o
);
  import cdd_pkg::*;

  // input register
  logic   in_valid_q;
  day_t   first_day_q,   second_day_q;
  month_t first_month_q, second_month_q;
  year_t  first_year_q,  second_year_q;

  // result register
  logic  out_valid_q;
  diff_t diff_q, diff_d;

  logic     out_free;
  logic     in_free;
  logic     advance;
  day_num_t first_num;
  day_num_t second_num;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_free    = !in_valid_q || out_free;
  assign in_ready_o = in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      first_day_q    <= first_day_i;
      first_month_q  <= first_month_i;
      first_year_q   <= first_year_i;
      second_day_q   <= second_day_i;
      second_month_q <= second_month_i;
      second_year_q  <= second_year_i;
    end
  end

  cdd_day_number u_first_num (
    .day_i     (first_day_q),
    .month_i   (first_month_q),
    .year_i    (first_year_q),
    .day_num_o (first_num)
  );

  cdd_day_number u_second_num (
    .day_i     (second_day_q),
    .month_i   (second_month_q),
    .year_i    (second_year_q),
    .day_num_o (second_num)
  );

  // day numbers stay below 2^23; the difference wraps to 23 bits, exact for spans under 2^22
  assign diff_d = $signed(second_num - first_num);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      diff_q <= diff_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign day_difference_o = diff_q;

`ifndef SYNTHESIS
  // a full input register that cannot move on blocks new requests
  a_block_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |-> !in_ready_o)
    else $error("input taken while both stages are full");

  // an empty pipeline always takes a request
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_q && !out_valid_q) |-> in_ready_o)
    else $error("empty pipeline refused a request");

  // a request that moves on appears as a result with its own difference
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_o && (day_difference_o == $past(diff_d))))
    else $error("result lost or corrupted on the way to the output");

  // an accepted request lands in the input register
  a_request_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> in_valid_q)
    else $error("accepted request dropped");
`endif

endmodule

// File: tb/day_difference_checker.sv
`timescale 1ns / 1ps

// Watches both channels, works out each request's day difference and
// compares the results in order.
module day_difference_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  cdd_pkg::day_t   first_day_i,
  input  cdd_pkg::month_t first_month_i,
  input  cdd_pkg::year_t  first_year_i,
  input  cdd_pkg::day_t   second_day_i,
  input  cdd_pkg::month_t second_month_i,
  input  cdd_pkg::year_t  second_year_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  cdd_pkg::diff_t  day_difference_i,
  output int              error_count_o,
  output int              pending_o
);
  import cdd_pkg::*;

  localparam int unsigned CommonYearDays = 365;
  localparam int unsigned LongMonthDays  = 31;
  localparam int unsigned LastMonth      = 13;

  // days before month k+1 of a common year, k = 0..12
  localparam int unsigned MonthStart[13] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
  };

  diff_t expected_diffs[$];

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // days since day 0 of year 0, year 0 counted as leap
  function automatic day_num_t day_number(input day_t d, input month_t m, input year_t y);
    int unsigned yr;
    int unsigned mo;
    int unsigned prev;
    int unsigned total;
    yr    = y;
    mo    = m;
    total = CommonYearDays * yr;
    if (yr > 0) begin
      prev  = yr - 1;
      total = total + prev / 4 - prev / 100 + prev / 400 + 1;
    end
    if (mo >= 1) begin
      if (mo <= LastMonth) begin
        total = total + MonthStart[mo - 1];
      end else begin
        total = total + CommonYearDays + LongMonthDays * (mo - LastMonth);
      end
      if (mo > 2 && leap_year(yr)) begin
        total = total + 1;
      end
    end
    total = total + d;
    return day_num_t'(total);
  endfunction

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  always @(posedge clk_i) begin
    diff_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_diffs.push_back(diff_t'(
          day_number(second_day_i, second_month_i, second_year_i) -
          day_number(first_day_i, first_month_i, first_year_i)));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_diffs.size() == 0) begin
          error_count_o = error_count_o + 1;
          $display("%0t: unexpected result %0d, none expected",
                   $time, day_difference_i);
        end else begin
          want = expected_diffs.pop_front();
          if (day_difference_i !== want) begin
            error_count_o = error_count_o + 1;
            $display("%0t: day_difference expected %0d, got %0d",
                     $time, want, day_difference_i);
          end
        end
      end
      pending_o = expected_diffs.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Stimulus for the day difference core: a directed set of corner dates, then
// random date pairs with random gaps on the request side and random stalls on
// the result side. Checking lives in day_difference_checker.
module testbench;
  import cdd_pkg::*;

  localparam int RandomRequests = 1500;
  localparam int QuietFrom      = 1200;  // no idling from this request on
  localparam int HoldAt         = 500;   // long result stall starts here
  localparam int HoldCycles     = 60;
  localparam int IdleLimit      = 2000;
  localparam int DrainCycles    = 8;

  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
  } date_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  day_t   first_day;
  month_t first_month;
  year_t  first_year;
  day_t   second_day;
  month_t second_month;
  year_t  second_year;
  logic   out_valid;
  logic   out_ready;
  diff_t  day_difference;

  int     error_count;
  int     pending;
  int     idle_cycles;
  bit     quiet;
  bit     hold_req;
  int     stall_left;

  calendar_day_difference_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .first_day_i      (first_day),
    .first_month_i    (first_month),
    .first_year_i     (first_year),
    .second_day_i     (second_day),
    .second_month_i   (second_month),
    .second_year_i    (second_year),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .day_difference_o (day_difference)
  );

  day_difference_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .first_day_i      (first_day),
    .first_month_i    (first_month),
    .first_year_i     (first_year),
    .second_day_i     (second_day),
    .second_month_i   (second_month),
    .second_year_i    (second_year),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .day_difference_i (day_difference),
    .error_count_o    (error_count),
    .pending_o        (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a long run of cycles with no handshake on either side means a hang.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: short random stalls, plus one long hold-off on request so
  // that both pipeline stages fill and in_ready drops.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else if (hold_req) begin
        out_ready  = 1'b0;
        stall_left = HoldCycles - 1;
        hold_req   = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offer one request and hold it until accepted. Called at a falling edge,
  // returns at a falling edge.
  task automatic send_pair(input date_t a, input date_t b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    first_day    = a.day;
    first_month  = a.month;
    first_year   = a.year;
    second_day   = b.day;
    second_month = b.month;
    second_year  = b.year;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_fields(input int d1, input int m1, input int y1,
                             input int d2, input int m2, input int y2);
    send_pair('{day_t'(d1), month_t'(m1), year_t'(y1)},
              '{day_t'(d2), month_t'(m2), year_t'(y2)});
  endtask

  // Mostly calendar-valid dates, some with raw full-width fields and some on
  // century boundaries where the leap rule turns.
  function automatic date_t random_date();
    date_t r;
    int    pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      r.month = month_t'($urandom_range(1, 12));
      r.day   = day_t'($urandom_range(1, 31));
      r.year  = year_t'($urandom_range(0, 9999));
    end else if (pick < 8) begin
      r.month = month_t'($urandom);
      r.day   = day_t'($urandom);
      r.year  = year_t'($urandom);
    end else begin
      r.month = month_t'($urandom_range(1, 13));
      r.day   = day_t'($urandom_range(0, 31));
      r.year  = year_t'(100 * $urandom_range(0, 163) + $urandom_range(0, 2) - 1);
    end
    return r;
  endfunction

  // Second date close to the first: same or adjacent year.
  function automatic date_t nearby_date(input date_t a);
    date_t r;
    r       = a;
    r.year  = year_t'(a.year + $urandom_range(0, 2) - 1);
    r.month = month_t'($urandom_range(1, 12));
    r.day   = day_t'($urandom_range(1, 31));
    return r;
  endfunction

  initial begin
    date_t a;
    date_t b;
    in_valid     = 1'b0;
    first_day    = '0;
    first_month  = '0;
    first_year   = '0;
    second_day   = '0;
    second_month = '0;
    second_year  = '0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // corner dates
    send_fields(0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 0, 127, 127, 16383);        // largest positive span
    send_fields(127, 127, 16383, 0, 0, 0);        // largest negative span
    send_fields(1, 1, 0, 1, 1, 1);                // year 0 is leap
    send_fields(1, 3, 0, 1, 3, 1);
    send_fields(28, 2, 2000, 1, 3, 2000);         // divisible by 400
    send_fields(28, 2, 1900, 1, 3, 1900);         // century, not leap
    send_fields(28, 2, 2004, 1, 3, 2004);
    send_fields(28, 2, 2001, 1, 3, 2001);
    send_fields(29, 2, 2400, 1, 3, 2400);
    send_fields(1, 2, 1, 1, 3, 1);
    send_fields(0, 1, 2020, 31, 12, 2020);        // day zero
    send_fields(99, 2, 2023, 1, 3, 2023);         // day past month end
    send_fields(1, 0, 2024, 1, 1, 2024);          // month zero
    send_fields(1, 12, 2024, 1, 13, 2024);        // month thirteen
    send_fields(1, 13, 2024, 1, 14, 2024);        // beyond thirteen: 31 days each
    send_fields(5, 99, 9999, 5, 127, 9999);
    send_fields(1, 1, 9999, 1, 1, 10000);         // past four digits
    send_fields(1, 1, 16383, 1, 1, 16000);
    send_fields(15, 6, 1970, 15, 6, 1970);
    send_fields(31, 12, 1999, 1, 1, 2000);
    send_fields(127, 0, 0, 0, 127, 0);
    send_fields(1, 1, 1600, 1, 1, 1700);
    send_fields(10, 10, 2100, 10, 10, 2000);

    for (int n = 0; n < RandomRequests; n++) begin
      if (n == HoldAt) hold_req = 1'b1;
      if (n == QuietFrom) quiet = 1'b1;
      a = random_date();
      b = ($urandom_range(0, 2) == 0) ? nearby_date(a) : random_date();
      if ($urandom_range(0, 1) == 0) begin
        send_pair(a, b);
      end else begin
        send_pair(b, a);
      end
    end
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
